// ===== sv/p1tf_pkg.sv =====
`default_nettype none

package p1tf_pkg;

    localparam int unsigned BUFFER_MAX = 4096;
    localparam int unsigned LEN_W = 13;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [7:0]  CH_START = 8'h2F;
    localparam logic [7:0]  CH_END   = 8'h21;
    localparam logic [7:0]  CASE_BIT = 8'h20;

    localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(BUFFER_MAX);

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_CRC_MISMATCH = 2'd1,
        ST_NO_START     = 2'd2,
        ST_OVERRUN      = 2'd3
    } t_status;

    typedef struct packed {
        logic             hit;
        t_status          status;
        logic [15:0]      computed_crc;
        logic [15:0]      recv_crc;
        logic [LEN_W-1:0] frame_length;
    } t_result;

    // Reflected CRC-16 update over one byte, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic hex_ok(input logic [7:0] b);
        logic [7:0] u;
        u = b & ~CASE_BIT;
        return ((b >= 8'h30) && (b <= 8'h39)) || ((u >= 8'h41) && (u <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] u;
        logic [7:0] d;
        u = b & ~CASE_BIT;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            d = b - 8'h30;
        end else begin
            d = u - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/p1tf_frame_state.sv =====
`default_nettype none

module p1tf_frame_state (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_commit,
    input  wire  [7:0]                   i_byte,
    input  wire  [p1tf_pkg::LEN_W-1:0]   i_limit,
    output p1tf_pkg::t_result            o_result
);

    logic [15:0]                 r_running_crc, n_running_crc;
    logic [15:0]                 r_saved_crc,   n_saved_crc;
    logic [15:0]                 r_hex_shift,   n_hex_shift;
    logic [2:0]                  r_hex_count,   n_hex_count;
    logic                        r_trailer,     n_trailer;
    logic                        r_start_seen,  n_start_seen;
    logic [p1tf_pkg::LEN_W-1:0]  r_fill_count,  n_fill_count;
    logic [p1tf_pkg::LEN_W-1:0]  r_span_count,  n_span_count;
    logic [p1tf_pkg::LEN_W-1:0]  r_saved_span,  n_saved_span;

    logic [p1tf_pkg::LEN_W-1:0]  limit_eff;
    logic                        overrun;
    logic                        is_hex;
    logic [15:0]                 shifted;
    logic [2:0]                  cnt_inc;
    logic                        done;
    logic                        flush;

    always_comb begin
        limit_eff = (i_limit > p1tf_pkg::LIMIT_RESET) ? p1tf_pkg::LIMIT_RESET : i_limit;
        overrun   = (r_fill_count >= limit_eff);
        is_hex    = p1tf_pkg::hex_ok(i_byte);
        shifted   = {r_hex_shift[11:0], p1tf_pkg::hex_val(i_byte)};
        cnt_inc   = r_hex_count + 3'd1;
        done      = 1'b0;
        flush     = 1'b0;

        n_running_crc = r_running_crc;
        n_saved_crc   = r_saved_crc;
        n_hex_shift   = r_hex_shift;
        n_hex_count   = r_hex_count;
        n_trailer     = r_trailer;
        n_start_seen  = r_start_seen;
        n_fill_count  = r_fill_count;
        n_span_count  = r_span_count;
        n_saved_span  = r_saved_span;

        o_result              = '0;
        o_result.status       = p1tf_pkg::ST_OVERRUN;

        if (overrun) begin
            flush        = 1'b1;
            o_result.hit = 1'b1;
        end else begin
            n_fill_count = r_fill_count + p1tf_pkg::LEN_W'(1);

            if (i_byte == p1tf_pkg::CH_START) begin
                n_start_seen  = 1'b1;
                n_running_crc = p1tf_pkg::crc_byte(p1tf_pkg::CRC_INIT, i_byte);
                n_span_count  = p1tf_pkg::LEN_W'(1);
            end else if (r_start_seen) begin
                n_running_crc = p1tf_pkg::crc_byte(r_running_crc, i_byte);
                n_span_count  = r_span_count + p1tf_pkg::LEN_W'(1);
            end

            if (r_trailer) begin
                if (is_hex) begin
                    n_hex_shift = shifted;
                    n_hex_count = cnt_inc;
                    if (cnt_inc == 3'd4) begin
                        done              = 1'b1;
                        flush             = 1'b1;
                        o_result.hit      = 1'b1;
                        o_result.recv_crc = shifted;
                        if (!n_start_seen) begin
                            o_result.status = p1tf_pkg::ST_NO_START;
                        end else begin
                            o_result.computed_crc = r_saved_crc;
                            o_result.frame_length = r_saved_span;
                            o_result.status = (r_saved_crc == shifted) ?
                                              p1tf_pkg::ST_OK : p1tf_pkg::ST_CRC_MISMATCH;
                        end
                    end
                end else begin
                    n_trailer   = 1'b0;
                    n_hex_count = 3'd0;
                    n_hex_shift = 16'h0000;
                end
            end

            // A closing mark latches the CRC and span that already include it.
            if (!done && (i_byte == p1tf_pkg::CH_END)) begin
                n_saved_crc  = n_start_seen ? n_running_crc : 16'h0000;
                n_saved_span = n_start_seen ? n_span_count : '0;
                n_trailer    = 1'b1;
                n_hex_count  = 3'd0;
                n_hex_shift  = 16'h0000;
            end
        end

        if (flush) begin
            n_running_crc = p1tf_pkg::CRC_INIT;
            n_saved_crc   = 16'h0000;
            n_hex_shift   = 16'h0000;
            n_hex_count   = 3'd0;
            n_trailer     = 1'b0;
            n_start_seen  = 1'b0;
            n_fill_count  = '0;
            n_span_count  = '0;
            n_saved_span  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_crc <= p1tf_pkg::CRC_INIT;
            r_saved_crc   <= 16'h0000;
            r_hex_shift   <= 16'h0000;
            r_hex_count   <= 3'd0;
            r_trailer     <= 1'b0;
            r_start_seen  <= 1'b0;
            r_fill_count  <= '0;
            r_span_count  <= '0;
            r_saved_span  <= '0;
        end else if (i_commit) begin
            r_running_crc <= n_running_crc;
            r_saved_crc   <= n_saved_crc;
            r_hex_shift   <= n_hex_shift;
            r_hex_count   <= n_hex_count;
            r_trailer     <= n_trailer;
            r_start_seen  <= n_start_seen;
            r_fill_count  <= n_fill_count;
            r_span_count  <= n_span_count;
            r_saved_span  <= n_saved_span;
        end
    end

endmodule

`default_nettype wire

// ===== sv/p1_telegram_framer_crc_check_core.sv =====
`default_nettype none

// Telegram framer with CRC-16 check: one received byte per transaction. Each
// byte is taken into an input register, then the framing state and CRC are
// updated from it, so a new byte can be taken every clock while o_stall is low.
// A result (status, computed and received CRC, frame length) is registered in
// the output register when the byte in the input register that completes a
// telegram or overflows the buffer limit advances; most bytes give no result.
// While a result waits on a stalled output, bytes that give no result keep
// flowing; a byte that would give a result waits in the input register.
// The buffer limit must be written through i_cfg_we/i_cfg_wdata only while no
// byte is in flight (not enforced by the block); values above 4096 act as 4096.
module p1_telegram_framer_crc_check_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [p1tf_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [7:0]                   i_data_byte,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [1:0]                   o_status,
    output logic [15:0]                  o_computed_crc,
    output logic [15:0]                  o_recv_crc,
    output logic [p1tf_pkg::LEN_W-1:0]   o_frame_length
);

    logic [p1tf_pkg::LEN_W-1:0]  r_buffer_limit;
    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;
    logic                        r_out_valid;
    logic [1:0]                  r_status;
    logic [15:0]                 r_computed_crc;
    logic [15:0]                 r_recv_crc;
    logic [p1tf_pkg::LEN_W-1:0]  r_frame_length;

    p1tf_pkg::t_result           result;
    logic                        out_free;
    logic                        advance;
    logic                        in_take;

    p1tf_frame_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_byte   (r_in_byte),
        .i_limit  (r_buffer_limit),
        .o_result (result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!result.hit || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_limit <= p1tf_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_buffer_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && result.hit) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.hit) begin
            r_status       <= result.status;
            r_computed_crc <= result.computed_crc;
            r_recv_crc     <= result.recv_crc;
            r_frame_length <= result.frame_length;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_computed_crc = r_computed_crc;
    assign o_recv_crc     = r_recv_crc;
    assign o_frame_length = r_frame_length;

endmodule

`default_nettype wire
